FILE: hdl/sorted_key_table_assert.svh
// Assertion macros shared by the sorted key table RTL.
// Depends on nothing; included by sorted_key_table, the module that carries checks.
`ifndef SORTED_KEY_TABLE_ASSERT_SVH
`define SORTED_KEY_TABLE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SKT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SKT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/skt_pkg.sv
// Shared types and codes for the sorted key table.
// Used by skt_cmp and sorted_key_table; depends on nothing.
package skt_pkg;

    // Width of the ordering key.
    localparam int KEY_W = 32;

    // Operation codes.
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_SEARCH = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    // Result of the shared key comparator.
    typedef struct packed {
        logic lt;
        logic eq;
    } t_cmp_res;

endpackage

FILE: hdl/sorted_key_table.sv
// Sorted key table: a scan of one entry per cycle, then a shift of one entry per cycle.
// Items are taken one at a time, the next accepted after the result is registered;
// one memory access per cycle sets the rate. A stalled result holds the next item in S_DONE.
// Reset clears the entry count and control state only; no memory clearing pass.
`include "sorted_key_table_assert.svh"

module sorted_key_table #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [1:0]                i_op,
    input  logic [skt_pkg::KEY_W-1:0] i_key,
    input  logic [31:0]               i_entry_data,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_found,
    output logic [31:0]               o_data_out,
    output logic [1:0]                o_status,
    output logic [6:0]                o_occupancy
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int DW = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;

    // Sequencer state codes.
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_START  = 3'd1;
    localparam logic [2:0] S_CMP    = 3'd2;
    localparam logic [2:0] S_INS_SH = 3'd3;
    localparam logic [2:0] S_INS_WR = 3'd4;
    localparam logic [2:0] S_DEL_SH = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0]                r_state, n_state;
    logic [CW-1:0]             r_count, n_count;
    logic [CW-1:0]             r_pos, n_pos;
    logic [CW-1:0]             r_idx, n_idx;
    logic [1:0]                r_op, n_op;
    logic [skt_pkg::KEY_W-1:0] r_key, n_key;
    logic [DW-1:0]             r_dat, n_dat;
    logic                      r_found, n_found;
    logic [31:0]               r_dout, n_dout;
    logic [1:0]                r_status, n_status;
    logic                      r_out_valid, n_out_valid;
    logic                      r_o_found, n_o_found;
    logic [31:0]               r_o_dout, n_o_dout;
    logic [1:0]                r_o_status, n_o_status;
    logic [6:0]                r_o_occ, n_o_occ;

    logic                      mem_we;
    logic [AW-1:0]             mem_waddr;
    logic [AW-1:0]             mem_raddr;
    logic [skt_pkg::KEY_W-1:0] mem_wkey;
    logic [DW-1:0]             mem_wdata;
    logic [skt_pkg::KEY_W-1:0] rd_key;
    logic [DW-1:0]             rd_data;
    skt_pkg::t_cmp_res         cmp_res;

    // Scan outcome seen by the decision logic.
    logic                      scan_end;
    logic                      scan_match;
    logic [CW-1:0]             scan_pos;
    logic [CW-1:0]             pos_inc;

    // Key and data stores.
    skt_ram #(.WIDTH(skt_pkg::KEY_W), .DEPTH(CAPACITY)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wkey),
        .i_raddr (mem_raddr),
        .o_rdata (rd_key)
    );

    skt_ram #(.WIDTH(DW), .DEPTH(CAPACITY)) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (rd_data)
    );

    // Shared comparator of the entry just read against the item key.
    skt_cmp u_cmp (
        .i_a   (rd_key),
        .i_b   (r_key),
        .o_res (cmp_res)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign pos_inc    = r_pos + CW'(1);

    // Sequencer: scan, decide, shift and write as the operation needs, then hand the result to the output register.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_pos       = r_pos;
        n_idx       = r_idx;
        n_op        = r_op;
        n_key       = r_key;
        n_dat       = r_dat;
        n_found     = r_found;
        n_dout      = r_dout;
        n_status    = r_status;
        n_out_valid = r_out_valid & i_out_stall;
        n_o_found   = r_o_found;
        n_o_dout    = r_o_dout;
        n_o_status  = r_o_status;
        n_o_occ     = r_o_occ;
        mem_we      = 1'b0;
        mem_waddr   = r_pos[AW-1:0];
        mem_raddr   = r_idx[AW-1:0];
        mem_wkey    = r_key;
        mem_wdata   = r_dat;
        scan_end    = 1'b0;
        scan_match  = 1'b0;
        scan_pos    = r_pos;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op     = i_op;
                    n_key    = i_key;
                    n_dat    = i_entry_data[DW-1:0];
                    n_pos    = '0;
                    n_found  = 1'b0;
                    n_dout   = '0;
                    n_status = skt_pkg::ST_OK;
                    if (i_op == skt_pkg::OP_INSERT || i_op == skt_pkg::OP_DELETE ||
                        i_op == skt_pkg::OP_SEARCH) begin
                        n_state = S_START;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_START: begin
                if (r_count == '0) begin
                    scan_end = 1'b1;
                end else begin
                    mem_raddr = '0;
                    n_state   = S_CMP;
                end
            end
            S_CMP: begin
                if (cmp_res.lt) begin
                    n_pos = pos_inc;
                    if (pos_inc == r_count) begin
                        scan_end = 1'b1;
                        scan_pos = pos_inc;
                    end else begin
                        mem_raddr = pos_inc[AW-1:0];
                    end
                end else begin
                    scan_end   = 1'b1;
                    scan_match = cmp_res.eq;
                end
            end
            S_INS_SH: begin
                // Move entry r_idx up by one place.
                mem_we    = 1'b1;
                mem_waddr = AW'(r_idx + CW'(1));
                mem_wkey  = rd_key;
                mem_wdata = rd_data;
                if (r_idx == r_pos) begin
                    n_state = S_INS_WR;
                end else begin
                    n_idx     = r_idx - CW'(1);
                    mem_raddr = AW'(r_idx - CW'(1));
                end
            end
            S_INS_WR: begin
                mem_we  = 1'b1;
                n_count = r_count + CW'(1);
                n_state = S_DONE;
            end
            S_DEL_SH: begin
                // Move entry r_idx down by one place.
                mem_we    = 1'b1;
                mem_waddr = AW'(r_idx - CW'(1));
                mem_wkey  = rd_key;
                mem_wdata = rd_data;
                if (r_idx == r_count - CW'(1)) begin
                    n_count = r_count - CW'(1);
                    n_state = S_DONE;
                end else begin
                    n_idx     = r_idx + CW'(1);
                    mem_raddr = AW'(r_idx + CW'(1));
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_o_found   = r_found;
                    n_o_dout    = r_dout;
                    n_o_status  = r_status;
                    n_o_occ     = 7'(r_count);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Decision once the scan has found the place of the key.
        if (scan_end) begin
            n_pos   = scan_pos;
            n_state = S_DONE;
            unique case (r_op)
                skt_pkg::OP_INSERT: begin
                    if (r_count == CW'(CAPACITY)) begin
                        n_status = skt_pkg::ST_FULL;
                    end else if (scan_pos == r_count) begin
                        n_state = S_INS_WR;
                    end else begin
                        n_idx     = r_count - CW'(1);
                        mem_raddr = AW'(r_count - CW'(1));
                        n_state   = S_INS_SH;
                    end
                end
                skt_pkg::OP_DELETE: begin
                    if (!scan_match) begin
                        n_status = skt_pkg::ST_NOT_FOUND;
                    end else begin
                        n_found = 1'b1;
                        if (scan_pos + CW'(1) == r_count) begin
                            n_count = r_count - CW'(1);
                        end else begin
                            n_idx     = scan_pos + CW'(1);
                            mem_raddr = AW'(scan_pos + CW'(1));
                            n_state   = S_DEL_SH;
                        end
                    end
                end
                skt_pkg::OP_SEARCH: begin
                    if (scan_match) begin
                        n_found = 1'b1;
                        n_dout  = 32'(rd_data);
                    end else begin
                        n_status = skt_pkg::ST_NOT_FOUND;
                    end
                end
                default: begin
                    n_status = skt_pkg::ST_OK;
                end
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_pos      <= n_pos;
        r_idx      <= n_idx;
        r_op       <= n_op;
        r_key      <= n_key;
        r_dat      <= n_dat;
        r_found    <= n_found;
        r_dout     <= n_dout;
        r_status   <= n_status;
        r_o_found  <= n_o_found;
        r_o_dout   <= n_o_dout;
        r_o_status <= n_o_status;
        r_o_occ    <= n_o_occ;
    end

    assign o_out_valid = r_out_valid;
    assign o_found     = r_o_found;
    assign o_data_out  = r_o_dout;
    assign o_status    = r_o_status;
    assign o_occupancy = r_o_occ;

    // Checks on the sequencer and the result.
    `SKT_ASSERT_IMP(a_count_max, i_clk, i_rst_n, 1'b1, r_count <= CW'(CAPACITY),
                    "entry count above capacity")
    `SKT_ASSERT_IMP(a_idle_no_write, i_clk, i_rst_n, r_state == S_IDLE, !mem_we,
                    "memory write while idle")
    `SKT_ASSERT_NXT(a_idle_count, i_clk, i_rst_n, r_state == S_IDLE, $stable(r_count),
                    "entry count moved while idle")
    `SKT_ASSERT_IMP(a_found_ok, i_clk, i_rst_n, r_out_valid && r_o_found,
                    r_o_status == skt_pkg::ST_OK, "found result without ok status")
    `SKT_ASSERT_IMP(a_full_count, i_clk, i_rst_n,
                    r_state == S_DONE && r_status == skt_pkg::ST_FULL,
                    r_count == CW'(CAPACITY), "full status with free entries")

endmodule

FILE: hdl/skt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module skt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/skt_cmp.sv
// Shared signed key comparator used by every step of the table scan.
// Depends on skt_pkg.
module skt_cmp (
    input  logic [skt_pkg::KEY_W-1:0] i_a,
    input  logic [skt_pkg::KEY_W-1:0] i_b,
    output skt_pkg::t_cmp_res         o_res
);

    // Signed less-than and equality of the stored key against the item key.
    always_comb begin
        o_res.lt = $signed(i_a) < $signed(i_b);
        o_res.eq = (i_a == i_b);
    end

endmodule
